FILE: rtl/core/fdpm_pkg.sv
package fdpm_pkg;

  // CORDIC datapath: 20 rotations on Q2.30 values, phase in turns of 2^32.
  localparam int CordicSteps = 20;
  localparam logic signed [31:0] CordicX0 = 32'sd652032874;
  localparam logic [29:0] InvTwoPi = 30'd683565276;

  // Angle divider: 43 quotient bits, remainder as wide as the radius.
  localparam int DivBits = 43;
  localparam int RemW = 15;

  // Configuration register indexes.
  localparam logic [2:0] RegCenterX = 3'd0;
  localparam logic [2:0] RegCenterY = 3'd1;
  localparam logic [2:0] RegSpanWidth = 3'd2;
  localparam logic [2:0] RegSpanHeight = 3'd3;
  localparam logic [2:0] RegInnerRadius = 3'd4;
  localparam logic [2:0] RegCenterRadius = 3'd5;
  localparam logic [2:0] RegBulgeGain = 3'd6;
  localparam logic [2:0] RegAngleOffset = 3'd7;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [1:0]         quad;
  } cordic_t;

  typedef struct packed {
    logic [RemW-1:0]    rem;
    logic [DivBits-1:0] w;
    logic               neg;
  } div_t;

  // Arctangent of 2^-step as a fraction of a full turn (2^32).
  function automatic logic signed [31:0] atan_turn(input int step);
    logic signed [31:0] a;
    case (step)
      0:  a = 32'sd536870912;
      1:  a = 32'sd316933406;
      2:  a = 32'sd167458907;
      3:  a = 32'sd85004756;
      4:  a = 32'sd42667331;
      5:  a = 32'sd21354465;
      6:  a = 32'sd10679838;
      7:  a = 32'sd5340245;
      8:  a = 32'sd2670163;
      9:  a = 32'sd1335087;
      10: a = 32'sd667544;
      11: a = 32'sd333772;
      12: a = 32'sd166886;
      13: a = 32'sd83443;
      14: a = 32'sd41722;
      15: a = 32'sd20861;
      16: a = 32'sd10430;
      17: a = 32'sd5215;
      18: a = 32'sd2608;
      19: a = 32'sd1304;
      default: a = 32'sd0;
    endcase
    return a;
  endfunction

  // Fold the first-quadrant rotation result back into the full circle.
  function automatic logic signed [31:0] cordic_sin(input cordic_t c);
    logic signed [31:0] s;
    case (c.quad)
      2'd0: s = c.y;
      2'd1: s = c.x;
      2'd2: s = -c.y;
      default: s = -c.x;
    endcase
    return s;
  endfunction

  function automatic logic signed [31:0] cordic_cos(input cordic_t c);
    logic signed [31:0] s;
    case (c.quad)
      2'd0: s = c.x;
      2'd1: s = -c.y;
      2'd2: s = -c.x;
      default: s = c.y;
    endcase
    return s;
  endfunction

endpackage

FILE: rtl/core/fdpm_cordic_cell.sv
module fdpm_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic              clk_i,
  input  fdpm_pkg::cordic_t cell_i,
  output fdpm_pkg::cordic_t cell_o
);
  import fdpm_pkg::*;

  logic signed [31:0] dx;
  logic signed [31:0] dy;
  logic signed [31:0] at;

  assign dx = $signed(cell_i.y) >>> STEP;
  assign dy = $signed(cell_i.x) >>> STEP;
  assign at = atan_turn(STEP);

  // One rotation toward zero residual angle.
  always_ff @(posedge clk_i) begin
    if (!cell_i.z[31]) begin
      cell_o.x <= cell_i.x - dx;
      cell_o.y <= cell_i.y + dy;
      cell_o.z <= cell_i.z - at;
    end else begin
      cell_o.x <= cell_i.x + dx;
      cell_o.y <= cell_i.y - dy;
      cell_o.z <= cell_i.z + at;
    end
    cell_o.quad <= cell_i.quad;
  end

endmodule

FILE: rtl/core/fdpm_div_cell.sv
module fdpm_div_cell (
  input  logic                       clk_i,
  input  logic [fdpm_pkg::RemW-1:0]  divisor_i,
  input  fdpm_pkg::div_t             cell_i,
  output fdpm_pkg::div_t             cell_o
);
  import fdpm_pkg::*;

  logic [RemW:0] r2;
  logic [RemW:0] diff;
  logic          ge;

  // Bring down the next dividend bit and try one subtraction.
  assign r2   = {cell_i.rem, cell_i.w[DivBits-1]};
  assign diff = r2 - {1'b0, divisor_i};
  assign ge   = (r2 >= {1'b0, divisor_i});

  always_ff @(posedge clk_i) begin
    cell_o.rem <= ge ? diff[RemW-1:0] : r2[RemW-1:0];
    cell_o.w   <= {cell_i.w[DivBits-2:0], ge};
    cell_o.neg <= cell_i.neg;
  end

endmodule

FILE: rtl/core/fdpm_delay.sv
module fdpm_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] tap_q [DEPTH];

  // Plain shift line that keeps a side value aligned with the main path.
  always_ff @(posedge clk_i) begin
    tap_q[0] <= d_i;
    for (int i = 1; i < DEPTH; i++) begin
      tap_q[i] <= tap_q[i-1];
    end
  end

  assign q_o = tap_q[DEPTH-1];

endmodule

FILE: rtl/core/fisheye_dewarp_pixel_map_unit.sv
// Fisheye polar dewarp address generator with bilinear taps.
// Input channel: a beat is taken at a rising edge with start high and busy
// low. busy is always low, so one coordinate pair can enter every cycle.
// Result channel: done_o marks one cycle in which the four tap byte offsets
// and the four Q0.16 weights are valid; the receiver must take them then.
// Throughput is one beat per cycle: every step is a register stage of a fixed
// pipeline (a 43-cell restoring divider for the angle and 20-cell CORDIC rows
// for the sines and cosines).
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i at the
// edge; write only while no beat is in flight.
// Reset clears the pipeline valid bits and loads the register defaults;
// beats in flight at reset are dropped.
module fisheye_dewarp_pixel_map_unit #(
  parameter int SRC_WIDTH = 2048,
  parameter int SRC_HEIGHT = 2048,
  parameter int BYTES_PER_PIXEL = 3
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] norm_x_i,
  input  logic [15:0] norm_y_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [18:0] cfg_data_i,
  output logic        done_o,
  output logic [23:0] tap_top_left_o,
  output logic [23:0] tap_top_right_o,
  output logic [23:0] tap_bottom_left_o,
  output logic [23:0] tap_bottom_right_o,
  output logic [16:0] weight_top_left_o,
  output logic [16:0] weight_top_right_o,
  output logic [16:0] weight_bottom_left_o,
  output logic [16:0] weight_bottom_right_o
);
  import fdpm_pkg::*;

  localparam int Lat = 71;
  localparam int IXW = $clog2(SRC_WIDTH);
  localparam int IYW = $clog2(SRC_HEIGHT);
  localparam logic signed [41:0] XHi = 42'(longint'(SRC_WIDTH - 2) << 20);
  localparam logic signed [41:0] YHi = 42'(longint'(SRC_HEIGHT - 2) << 20);
  localparam logic [25:0] BppC = 26'(BYTES_PER_PIXEL);
  localparam logic [25:0] RowC = 26'(SRC_WIDTH * BYTES_PER_PIXEL);

  // Configuration registers.
  logic [14:0]        cx_q, cy_q, sh_q, ir_q, cr_q;
  logic [17:0]        sw_q;
  logic signed [15:0] bulge_q;
  logic signed [18:0] ao_q;
  logic [RemW-1:0]    divisor;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q    <= 15'd16384;
      cy_q    <= 15'd16384;
      sw_q    <= 18'd16384;
      sh_q    <= 15'd4096;
      ir_q    <= 15'd4096;
      cr_q    <= 15'd8192;
      bulge_q <= '0;
      ao_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegCenterX:      cx_q    <= cfg_data_i[14:0];
        RegCenterY:      cy_q    <= cfg_data_i[14:0];
        RegSpanWidth:    sw_q    <= cfg_data_i[17:0];
        RegSpanHeight:   sh_q    <= cfg_data_i[14:0];
        RegInnerRadius:  ir_q    <= cfg_data_i[14:0];
        RegCenterRadius: cr_q    <= cfg_data_i[14:0];
        RegBulgeGain:    bulge_q <= cfg_data_i[15:0];
        RegAngleOffset:  ao_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A center radius below one pixel is used as one pixel.
  assign divisor = (cr_q < 15'd16) ? 15'd16 : cr_q;

  // Handshake and valid line.
  logic            accept;
  logic [Lat-1:0]  vld_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Lat-2:0], accept};
    end
  end

  assign done_o = vld_q[Lat-1];

  // Stage 1: angle numerator magnitude, radial product, CORDIC seeds.
  logic [33:0]        usw;
  logic signed [35:0] a_w;
  logic [34:0]        mag;
  logic [30:0]        vsh_q;
  div_t               div_chain [DivBits+1];
  cordic_t            u_chain [CordicSteps+1];
  cordic_t            v_chain [CordicSteps+1];
  cordic_t            p_chain [CordicSteps+1];

  assign usw = norm_x_i * sw_q;
  assign a_w = $signed({2'b00, usw}) + $signed({ao_q[18], ao_q, 16'h0000});
  assign mag = a_w[35] ? (~a_w[34:0] + 35'd1) : a_w[34:0];

  always_ff @(posedge clk_i) begin
    div_chain[0] <= '{rem: '0, w: {mag, 8'h00}, neg: a_w[35]};
    vsh_q        <= norm_y_i * sh_q;
    u_chain[0]   <= '{x: CordicX0, y: '0,
                      z: $signed({2'b00, norm_x_i[14:0], 15'h0000}),
                      quad: {1'b0, norm_x_i[15]}};
    v_chain[0]   <= '{x: CordicX0, y: '0,
                      z: $signed({2'b00, norm_y_i, 14'h0000}),
                      quad: 2'b00};
  end

  // Divider row and the two bulge CORDIC rows.
  for (genvar k = 0; k < DivBits; k++) begin : g_div
    fdpm_div_cell u_cell (
      .clk_i    (clk_i),
      .divisor_i(divisor),
      .cell_i   (div_chain[k]),
      .cell_o   (div_chain[k+1])
    );
  end

  for (genvar k = 0; k < CordicSteps; k++) begin : g_bulge
    fdpm_cordic_cell #(.STEP(k)) u_ucell (
      .clk_i (clk_i),
      .cell_i(u_chain[k]),
      .cell_o(u_chain[k+1])
    );
    fdpm_cordic_cell #(.STEP(k)) u_vcell (
      .clk_i (clk_i),
      .cell_i(v_chain[k]),
      .cell_o(v_chain[k+1])
    );
  end

  // Stages 22 to 24: bulge term and radius.
  logic signed [31:0] sin_u, sin_v;
  logic signed [63:0] suv_q;
  logic signed [33:0] s_w;
  logic signed [49:0] bp_q;
  logic [30:0]        vsh_dly;
  logic signed [36:0] r_w;
  logic [28:0]        r12_q;

  assign sin_u = cordic_sin(u_chain[CordicSteps]);
  assign sin_v = cordic_sin(v_chain[CordicSteps]);
  assign s_w   = $signed(suv_q[63:30]);

  fdpm_delay #(.WIDTH(31), .DEPTH(22)) u_vsh_dly (
    .clk_i(clk_i),
    .d_i  (vsh_q),
    .q_o  (vsh_dly)
  );

  assign r_w = $signed({6'b0, vsh_dly}) + $signed({6'b0, ir_q, 16'h0000})
             + $signed(bp_q[49:14]);

  always_ff @(posedge clk_i) begin
    suv_q <= sin_u * sin_v;
    bp_q  <= bulge_q * s_w;
    r12_q <= r_w[36:8];
  end

  // Stages 45 to 47: signed angle and phase in turns.
  logic signed [40:0] t_q;
  logic signed [51:0] ph_full;
  logic [35:0]        ph_q;
  logic [49:0]        pl_q;
  logic [55:0]        sum56;
  logic [31:0]        phase;
  logic [40:0]        quo;

  assign quo     = {1'b0, div_chain[DivBits].w[39:0]};
  assign ph_full = $signed(t_q[40:20]) * $signed({1'b0, InvTwoPi});
  assign sum56   = {ph_q, 20'h00000} + {6'h00, pl_q};
  assign phase   = sum56[55:24];

  always_ff @(posedge clk_i) begin
    t_q        <= div_chain[DivBits].neg ? (41'd0 - quo) : quo;
    ph_q       <= ph_full[35:0];
    pl_q       <= t_q[19:0] * InvTwoPi;
    p_chain[0] <= '{x: CordicX0, y: '0, z: $signed({2'b00, phase[29:0]}),
                    quad: phase[31:30]};
  end

  for (genvar k = 0; k < CordicSteps; k++) begin : g_angle
    fdpm_cordic_cell #(.STEP(k)) u_pcell (
      .clk_i (clk_i),
      .cell_i(p_chain[k]),
      .cell_o(p_chain[k+1])
    );
  end

  // Stages 68 to 70: source point, saturation and fractions.
  logic signed [31:0] st_q, ct_q;
  logic [28:0]        r12_dly;
  logic signed [60:0] mx_q, my_q;
  logic signed [41:0] px_w, py_w, pxc, pyc;
  logic [IXW-1:0]     ix_q;
  logic [IYW-1:0]     iy_q;
  logic [15:0]        fx_q, fy_q;
  logic [16:0]        ox_q, oy_q;

  fdpm_delay #(.WIDTH(29), .DEPTH(44)) u_r12_dly (
    .clk_i(clk_i),
    .d_i  (r12_q),
    .q_o  (r12_dly)
  );

  assign px_w = $signed({11'b0, cx_q, 16'h0000}) + $signed(mx_q[60:22]);
  assign py_w = $signed({11'b0, cy_q, 16'h0000}) + $signed(my_q[60:22]);

  always_comb begin
    pxc = px_w;
    if (px_w < 0) begin
      pxc = '0;
    end else if (px_w > XHi) begin
      pxc = XHi;
    end
    pyc = py_w;
    if (py_w < 0) begin
      pyc = '0;
    end else if (py_w > YHi) begin
      pyc = YHi;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= cordic_sin(p_chain[CordicSteps]);
    ct_q <= cordic_cos(p_chain[CordicSteps]);
    mx_q <= $signed(r12_dly) * st_q;
    my_q <= $signed(r12_dly) * ct_q;
    ix_q <= pxc[20 +: IXW];
    iy_q <= pyc[20 +: IYW];
    fx_q <= pxc[19:4];
    fy_q <= pyc[19:4];
    ox_q <= 17'd65536 - {1'b0, pxc[19:4]};
    oy_q <= 17'd65536 - {1'b0, pyc[19:4]};
  end

  // Stage 71: byte offsets and rounded weights.
  logic [25:0] tl_w;
  logic [34:0] w_tl, w_tr, w_bl, w_br;

  assign tl_w = 26'(ix_q) * BppC + 26'(iy_q) * RowC;
  assign w_tl = ox_q * oy_q + 35'd32768;
  assign w_tr = fx_q * oy_q + 35'd32768;
  assign w_bl = ox_q * fy_q + 35'd32768;
  assign w_br = fx_q * fy_q + 35'd32768;

  always_ff @(posedge clk_i) begin
    tap_top_left_o        <= tl_w[23:0];
    tap_top_right_o       <= 24'(tl_w + BppC);
    tap_bottom_left_o     <= 24'(tl_w + RowC);
    tap_bottom_right_o    <= 24'(tl_w + RowC + BppC);
    weight_top_left_o     <= w_tl[32:16];
    weight_top_right_o    <= w_tr[32:16];
    weight_bottom_left_o  <= w_bl[32:16];
    weight_bottom_right_o <= w_br[32:16];
  end

`ifndef NO_ASSERTIONS
  logic [18:0] wsum;
  assign wsum = 19'(weight_top_left_o) + 19'(weight_top_right_o)
              + 19'(weight_bottom_left_o) + 19'(weight_bottom_right_o);

  a_clamp_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[Lat-2] |-> (32'(ix_q) <= 32'(SRC_WIDTH - 2)))
    else $error("saturated column lies outside the source image");

  a_clamp_y: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[Lat-2] |-> (32'(iy_q) <= 32'(SRC_HEIGHT - 2)))
    else $error("saturated row lies outside the source image");

  a_weight_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (wsum >= 19'd65534 && wsum <= 19'd65538))
    else $error("bilinear weights do not sum to one");
`endif

endmodule

FILE: verif/fisheye_dewarp_pixel_map_unit_tb.sv
`timescale 1ns / 100ps

module fisheye_dewarp_pixel_map_unit_tb;
  import fdpm_pkg::*;

  localparam int SrcW = 2048;
  localparam int SrcH = 2048;
  localparam int Bpp = 3;
  localparam int Latency = 71;

  typedef struct packed {
    logic [15:0] nx;
    logic [15:0] ny;
  } coord_t;

  typedef struct packed {
    logic [23:0] tl;
    logic [23:0] tr;
    logic [23:0] bl;
    logic [23:0] br;
    logic [16:0] wtl;
    logic [16:0] wtr;
    logic [16:0] wbl;
    logic [16:0] wbr;
  } taps_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [15:0] norm_x_i = '0;
  logic [15:0] norm_y_i = '0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [18:0] cfg_data_i = '0;
  logic        done_o;
  logic [23:0] tap_top_left_o, tap_top_right_o, tap_bottom_left_o, tap_bottom_right_o;
  logic [16:0] weight_top_left_o, weight_top_right_o;
  logic [16:0] weight_bottom_left_o, weight_bottom_right_o;

  // Shadow copies of the mapping registers.
  logic [14:0] cx_q, cy_q, height_q, rin_q, rmid_q;
  logic [17:0] width_q;
  logic [15:0] bulge_q;
  logic [18:0] offset_q;

  coord_t pending_coords[$];
  taps_t  expected_taps[$];
  int     idle_pct = 0;
  bit     feeding = 1'b0;
  int     errors = 0;

  fisheye_dewarp_pixel_map_unit #(
    .SRC_WIDTH(SrcW), .SRC_HEIGHT(SrcH), .BYTES_PER_PIXEL(Bpp)
  ) uut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic longint floor_sh(longint x, int s);
    return x >>> s;
  endfunction

  // Quadrant-folded CORDIC rotation giving sine and cosine in Q2.30.
  function automatic void rotate(logic [31:0] ph, output longint sn, output longint cs);
    longint x, y, z, dx, dy;
    longint atab[20] = '{536870912, 316933406, 167458907, 85004756, 42667331,
                         21354465, 10679838, 5340245, 2670163, 1335087, 667544,
                         333772, 166886, 83443, 41722, 20861, 10430, 5215,
                         2608, 1304};
    x = 652032874;
    y = 0;
    z = longint'(ph[29:0]);
    for (int i = 0; i < 20; i++) begin
      dx = floor_sh(y, i);
      dy = floor_sh(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atab[i];
      end else begin
        x += dx; y -= dy; z += atab[i];
      end
    end
    case (ph[31:30])
      2'd0: begin sn = y; cs = x; end
      2'd1: begin sn = x; cs = -y; end
      2'd2: begin sn = -y; cs = -x; end
      default: begin sn = -x; cs = y; end
    endcase
  endfunction

  function automatic longint clip(longint v, longint hi);
    if (v < 0) return 0;
    return (v > hi) ? hi : v;
  endfunction

  // Source taps and bilinear weights for one output coordinate.
  function automatic taps_t map_coord(coord_t c);
    longint a, t, r, r12, s, su, cu, sv, cv, st, ct, px, py;
    longint dv, mag, fx, fy, ox, oy, tl;
    logic [63:0] prod;
    taps_t o;
    dv = (rmid_q < 16) ? 16 : rmid_q;
    a = longint'(c.nx) * width_q + longint'(signed'(offset_q)) * 65536;
    mag = (a < 0) ? -a : a;
    t = (mag * 256) / dv;
    if (a < 0) t = -t;
    prod = 64'(t) * 64'd683565276;
    rotate(prod[55:24], st, ct);
    rotate({c.nx, 15'd0} & 32'hFFFFFFFF, su, cu);
    rotate(32'({c.ny, 14'd0}), sv, cv);
    s = floor_sh(su * sv, 30);
    r = longint'(c.ny) * height_q + longint'(rin_q) * 65536
        + floor_sh(longint'(signed'(bulge_q)) * s, 14);
    r12 = floor_sh(r, 8);
    px = clip(longint'(cx_q) * 65536 + floor_sh(r12 * st, 22), longint'(SrcW - 2) << 20);
    py = clip(longint'(cy_q) * 65536 + floor_sh(r12 * ct, 22), longint'(SrcH - 2) << 20);
    fx = (px >> 4) & 16'hFFFF;
    fy = (py >> 4) & 16'hFFFF;
    ox = 65536 - fx;
    oy = 65536 - fy;
    tl = ((px >> 20) + (py >> 20) * SrcW) * Bpp;
    o.tl = 24'(tl);
    o.tr = 24'(tl + Bpp);
    o.bl = 24'(tl + SrcW * Bpp);
    o.br = 24'(tl + SrcW * Bpp + Bpp);
    o.wtl = 17'((ox * oy + 32768) >> 16);
    o.wtr = 17'((fx * oy + 32768) >> 16);
    o.wbl = 17'((ox * fy + 32768) >> 16);
    o.wbr = 17'((fx * fy + 32768) >> 16);
    return o;
  endfunction

  // Driver: one coordinate beat per accepted start, gaps by idle_pct.
  always @(negedge clk_i) begin
    if (feeding && pending_coords.size() > 0 &&
        $urandom_range(99) >= idle_pct) begin
      start <= 1'b1;
      norm_x_i <= pending_coords[0].nx;
      norm_y_i <= pending_coords[0].ny;
    end else begin
      start <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && start && !busy) begin
      expected_taps.push_back(map_coord(pending_coords.pop_front()));
    end
  end

  // Monitor: compare each result beat with the oldest expectation.
  always @(posedge clk_i) begin
    taps_t e;
    if (rst_ni && done_o) begin
      if (expected_taps.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        e = expected_taps.pop_front();
        if (tap_top_left_o !== e.tl) begin
          $error("tap_top_left exp %0d got %0d", e.tl, tap_top_left_o); errors++;
        end
        if (tap_top_right_o !== e.tr) begin
          $error("tap_top_right exp %0d got %0d", e.tr, tap_top_right_o); errors++;
        end
        if (tap_bottom_left_o !== e.bl) begin
          $error("tap_bottom_left exp %0d got %0d", e.bl, tap_bottom_left_o); errors++;
        end
        if (tap_bottom_right_o !== e.br) begin
          $error("tap_bottom_right exp %0d got %0d", e.br, tap_bottom_right_o); errors++;
        end
        if (weight_top_left_o !== e.wtl) begin
          $error("weight_top_left exp %0d got %0d", e.wtl, weight_top_left_o); errors++;
        end
        if (weight_top_right_o !== e.wtr) begin
          $error("weight_top_right exp %0d got %0d", e.wtr, weight_top_right_o); errors++;
        end
        if (weight_bottom_left_o !== e.wbl) begin
          $error("weight_bottom_left exp %0d got %0d", e.wbl, weight_bottom_left_o);
          errors++;
        end
        if (weight_bottom_right_o !== e.wbr) begin
          $error("weight_bottom_right exp %0d got %0d", e.wbr, weight_bottom_right_o);
          errors++;
        end
      end
    end
  end

  // Register write at one edge, mirrored into the shadow copy.
  task automatic write_reg(logic [2:0] idx, logic [18:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegCenterX: cx_q = val[14:0];
      RegCenterY: cy_q = val[14:0];
      RegSpanWidth: width_q = val[17:0];
      RegSpanHeight: height_q = val[14:0];
      RegInnerRadius: rin_q = val[14:0];
      RegCenterRadius: rmid_q = val[14:0];
      RegBulgeGain: bulge_q = val[15:0];
      default: offset_q = val;
    endcase
  endtask

  // Feed queued beats and wait until every result has come back.
  task automatic run_batch(int pct);
    idle_pct = pct;
    feeding = 1'b1;
    wait (pending_coords.size() == 0);
    @(negedge clk_i);
    feeding = 1'b0;
    wait (expected_taps.size() == 0);
    repeat (Latency + 5) @(negedge clk_i);
  endtask

  task automatic queue_random(int n);
    coord_t c;
    for (int i = 0; i < n; i++) begin
      c.nx = 16'($urandom);
      c.ny = 16'($urandom);
      pending_coords.push_back(c);
    end
  endtask

  task automatic random_setting();
    write_reg(RegCenterX, 19'($urandom_range(32767)));
    write_reg(RegCenterY, 19'($urandom_range(32767)));
    write_reg(RegSpanWidth, 19'($urandom_range(262143)));
    write_reg(RegSpanHeight, 19'($urandom_range(32767)));
    write_reg(RegInnerRadius, 19'($urandom_range(32767)));
    write_reg(RegCenterRadius, 19'($urandom_range(32767)));
    write_reg(RegBulgeGain, 19'($urandom));
    write_reg(RegAngleOffset, 19'($urandom));
  endtask

  initial begin
    coord_t c;
    cx_q = 15'd16384; cy_q = 15'd16384; width_q = 18'd16384;
    height_q = 15'd4096; rin_q = 15'd4096; rmid_q = 15'd8192;
    bulge_q = '0; offset_q = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: field extremes under reset defaults.
    for (int i = 0; i < 16; i++) begin
      c.nx = 16'(1 << i); c.ny = ~16'(1 << i);
      pending_coords.push_back(c);
    end
    pending_coords.push_back('0);
    pending_coords.push_back('1);
    pending_coords.push_back({16'h8000, 16'h0000});
    run_batch(0);

    // Extreme registers: radius below one pixel, huge bulge and offsets.
    write_reg(RegCenterRadius, 19'd0);
    write_reg(RegBulgeGain, 19'h08000);
    write_reg(RegAngleOffset, 19'h40000);
    write_reg(RegSpanWidth, 19'h3FFFF);
    write_reg(RegSpanHeight, 19'h7FFF);
    write_reg(RegInnerRadius, 19'h7FFF);
    write_reg(RegCenterX, 19'd0);
    write_reg(RegCenterY, 19'h7FFF);
    pending_coords.push_back('0);
    pending_coords.push_back('1);
    pending_coords.push_back({16'h4000, 16'hC000});
    queue_random(5);
    run_batch(0);
    write_reg(RegBulgeGain, 19'h07FFF);
    write_reg(RegAngleOffset, 19'h3FFFF);
    write_reg(RegCenterRadius, 19'd15);
    write_reg(RegInnerRadius, 19'd0);
    queue_random(5);
    run_batch(0);

    // Random phases across idle profiles and register settings.
    for (int p = 0; p < 8; p++) begin
      random_setting();
      if (p == 3) write_reg(RegCenterRadius, 19'h7FFF);
      queue_random(190);
      case (p % 4)
        0: run_batch(0);
        1: run_batch(88);
        2: run_batch(17);
        default: run_batch($urandom_range(60));
      endcase
    end

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: files.f
rtl/core/fdpm_pkg.sv
rtl/core/fdpm_cordic_cell.sv
rtl/core/fdpm_div_cell.sv
rtl/core/fdpm_delay.sv
rtl/core/fisheye_dewarp_pixel_map_unit.sv
verif/fisheye_dewarp_pixel_map_unit_tb.sv
